[hdl/dxt_transparency_mask_store_macros.svh]
// Assertion macros shared by the transparency mask store RTL.
// DXT_TM_ASSERT checks a property on clk_i outside of reset.
// DXT_TM_ASSERT_ALWAYS checks a property on clk_i at every edge, reset included.
`ifndef DXT_TRANSPARENCY_MASK_STORE_MACROS_SVH
`define DXT_TRANSPARENCY_MASK_STORE_MACROS_SVH
`ifndef SYNTHESIS
`define DXT_TM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define DXT_TM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define DXT_TM_ASSERT(lbl, prop, msg)
`define DXT_TM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[hdl/dxt_tm_pkg.sv]
// ----------------------------------------------------------------------------
// dxt_tm_pkg
// Types, codes and sizes shared by the transparency mask store.
// ----------------------------------------------------------------------------
`default_nettype none

package dxt_tm_pkg;

  localparam int MAX_WIDTH      = 1024;
  localparam int MAX_HEIGHT     = 1024;
  localparam int BLOCKS_PER_ROW = (MAX_WIDTH + 3) / 4;
  localparam int BLOCK_ROWS     = (MAX_HEIGHT + 3) / 4;
  localparam int DEPTH          = BLOCKS_PER_ROW * BLOCK_ROWS;
  localparam int ADDR_W         = $clog2(DEPTH);

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

  localparam logic [1:0] DXT1_IDX_TRANSP = 2'h3;
  localparam logic [3:0] DXT3_ALPHA_ZERO = 4'h0;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_BLOCK = 2'd1,
    CMD_PIXEL = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STS_DONE    = 2'd0,
    STS_RANGE   = 2'd1,
    STS_IGNORED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    FMT_RAW   = 2'd0,
    FMT_DXT1  = 2'd1,
    FMT_DXT3  = 2'd2,
    FMT_OTHER = 2'd3
  } fmt_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_FORMAT = 2'd2
  } cfg_idx_e;

  // Work handed from the front to the back.
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_SET   = 2'd1,
    OP_QUERY = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       mask;
    status_e           status;
  } entry_t;

endpackage

`default_nettype wire

[hdl/dxt_tm_if.sv]
// ----------------------------------------------------------------------------
// dxt_tm_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface dxt_tm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [63:0] block_data;
  logic [7:0]  block_col;
  logic [7:0]  block_row;
  logic [9:0]  pixel_x;
  logic [9:0]  pixel_y;
  logic        alpha_is_zero;

  modport source (output valid, command, block_data, block_col, block_row, pixel_x,
                  pixel_y, alpha_is_zero, input ready);
  modport sink (input valid, command, block_data, block_col, block_row, pixel_x,
                pixel_y, alpha_is_zero, output ready);
endinterface

interface dxt_tm_out_if;
  logic       valid;
  logic       ready;
  logic       transparent;
  logic [1:0] status;

  modport source (output valid, transparent, status, input ready);
  modport sink (input valid, transparent, status, output ready);
endinterface

`default_nettype wire

[hdl/dxt_tm_front.sv]
// ----------------------------------------------------------------------------
// dxt_tm_front
// Holds the configuration and map-present flag, accepts command items and
// turns each into one store operation with its status already decided.
// ----------------------------------------------------------------------------
`default_nettype none

module dxt_tm_front (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire  [dxt_tm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire  [dxt_tm_pkg::CFG_W-1:0]       cfg_wdata_i,
  dxt_tm_in_if.sink                          in_i,
  output logic                               push_valid_o,
  output dxt_tm_pkg::entry_t                 push_entry_o,
  input  wire                                push_ready_i
);

  logic [dxt_tm_pkg::CFG_W-1:0] width_q, height_q;
  dxt_tm_pkg::fmt_e             fmt_q;
  logic                         present_q, present_d;
  logic [dxt_tm_pkg::CFG_W-1:0] eff_w, eff_h;
  logic [15:0]                  marks;
  logic                         blk_oor, pix_oor;
  logic [dxt_tm_pkg::ADDR_W-1:0] blk_addr, pix_addr;
  logic                         push;
  dxt_tm_pkg::entry_t           ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= dxt_tm_pkg::SIZE_RESET;
      height_q <= dxt_tm_pkg::SIZE_RESET;
      fmt_q    <= dxt_tm_pkg::FMT_RAW;
    end else if (cfg_we_i) begin
      unique case (dxt_tm_pkg::cfg_idx_e'(cfg_idx_i))
        dxt_tm_pkg::CFG_WIDTH:  width_q  <= cfg_wdata_i;
        dxt_tm_pkg::CFG_HEIGHT: height_q <= cfg_wdata_i;
        dxt_tm_pkg::CFG_FORMAT: fmt_q    <= dxt_tm_pkg::fmt_e'(cfg_wdata_i[1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= 1'b0;
    end else begin
      present_q <= present_d;
    end
  end

  // Sizes above the store's capacity behave as the capacity.
  always_comb begin
    eff_w = width_q;
    eff_h = height_q;
    if (32'(width_q) > dxt_tm_pkg::MAX_WIDTH) begin
      eff_w = dxt_tm_pkg::CFG_W'(dxt_tm_pkg::MAX_WIDTH);
    end
    if (32'(height_q) > dxt_tm_pkg::MAX_HEIGHT) begin
      eff_h = dxt_tm_pkg::CFG_W'(dxt_tm_pkg::MAX_HEIGHT);
    end
  end

  always_comb begin
    marks = '0;
    for (int k = 0; k < 16; k++) begin
      if (fmt_q == dxt_tm_pkg::FMT_DXT1) begin
        marks[k] = (in_i.block_data[15:0] <= in_i.block_data[31:16]) &&
                   (in_i.block_data[32+2*k +: 2] == dxt_tm_pkg::DXT1_IDX_TRANSP);
      end else if (fmt_q == dxt_tm_pkg::FMT_DXT3) begin
        marks[k] = (in_i.block_data[4*k +: 4] == dxt_tm_pkg::DXT3_ALPHA_ZERO);
      end
    end
  end

  // A partial last block column or row is out of range.
  assign blk_oor = ({1'b0, in_i.block_col} >= eff_w[10:2]) ||
                   ({1'b0, in_i.block_row} >= eff_h[10:2]);
  assign pix_oor = ({1'b0, in_i.pixel_x} >= eff_w) || ({1'b0, in_i.pixel_y} >= eff_h);

  assign blk_addr = dxt_tm_pkg::ADDR_W'(32'(in_i.block_row) * dxt_tm_pkg::BLOCKS_PER_ROW
                                        + 32'(in_i.block_col));
  assign pix_addr = dxt_tm_pkg::ADDR_W'(32'(in_i.pixel_y[9:2]) * dxt_tm_pkg::BLOCKS_PER_ROW
                                        + 32'(in_i.pixel_x[9:2]));

  always_comb begin
    ent.op     = dxt_tm_pkg::OP_NONE;
    ent.addr   = pix_addr;
    ent.mask   = 16'(1) << {in_i.pixel_y[1:0], in_i.pixel_x[1:0]};
    ent.status = dxt_tm_pkg::STS_DONE;
    if (dxt_tm_pkg::cmd_e'(in_i.command) == dxt_tm_pkg::CMD_CLEAR) begin
      ent.op = dxt_tm_pkg::OP_CLEAR;
    end else if (!present_q) begin
      ent.status = dxt_tm_pkg::STS_IGNORED;
    end else begin
      unique case (dxt_tm_pkg::cmd_e'(in_i.command))
        dxt_tm_pkg::CMD_BLOCK: begin
          ent.addr = blk_addr;
          ent.mask = marks;
          if (fmt_q == dxt_tm_pkg::FMT_RAW) begin
            ent.status = dxt_tm_pkg::STS_IGNORED;
          end else if (blk_oor) begin
            ent.status = dxt_tm_pkg::STS_RANGE;
          end else if (fmt_q != dxt_tm_pkg::FMT_OTHER) begin
            ent.op = dxt_tm_pkg::OP_SET;
          end
        end
        dxt_tm_pkg::CMD_PIXEL: begin
          if (fmt_q != dxt_tm_pkg::FMT_RAW) begin
            ent.status = dxt_tm_pkg::STS_IGNORED;
          end else if (pix_oor) begin
            ent.status = dxt_tm_pkg::STS_RANGE;
          end else if (in_i.alpha_is_zero) begin
            ent.op = dxt_tm_pkg::OP_SET;
          end
        end
        dxt_tm_pkg::CMD_QUERY: begin
          if (pix_oor) begin
            ent.status = dxt_tm_pkg::STS_RANGE;
          end else begin
            ent.op = dxt_tm_pkg::OP_QUERY;
          end
        end
        default: ;
      endcase
    end
  end

  assign push         = in_i.valid && push_ready_i;
  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;
  assign push_entry_o = ent;

  always_comb begin
    present_d = present_q;
    if (push && dxt_tm_pkg::cmd_e'(in_i.command) == dxt_tm_pkg::CMD_CLEAR) begin
      present_d = 1'b1;
    end
  end

endmodule

`default_nettype wire

[hdl/dxt_tm_queue.sv]
// ----------------------------------------------------------------------------
// dxt_tm_queue
// Two-entry queue of store operations between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module dxt_tm_queue (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_valid_i,
  input  dxt_tm_pkg::entry_t  push_entry_i,
  output logic                push_ready_o,
  output logic                pop_valid_o,
  output dxt_tm_pkg::entry_t  pop_entry_o,
  input  wire                 pop_ready_i
);

  dxt_tm_pkg::entry_t slot_q [2];
  logic               wr_ptr_q, wr_ptr_d;
  logic               rd_ptr_q, rd_ptr_d;
  logic [1:0]         count_q, count_d;
  logic               push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_entry_o  = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

[hdl/dxt_tm_back.sv]
// ----------------------------------------------------------------------------
// dxt_tm_back
// Owns the mask memory: runs read-modify-writes, queries and clearing
// sweeps, and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dxt_transparency_mask_store_macros.svh"

module dxt_tm_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 pop_valid_i,
  input  dxt_tm_pkg::entry_t  pop_entry_i,
  output logic                pop_ready_o,
  dxt_tm_out_if.source        out_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_CLR  = 2'd2;
  localparam logic [dxt_tm_pkg::ADDR_W-1:0] LAST_ADDR =
    dxt_tm_pkg::ADDR_W'(dxt_tm_pkg::DEPTH - 1);

  logic [15:0]                   mem_q [dxt_tm_pkg::DEPTH];
  logic [15:0]                   rdata_q;
  logic                          mem_we, mem_re;
  logic [dxt_tm_pkg::ADDR_W-1:0] mem_waddr;
  logic [15:0]                   mem_wdata;

  logic [1:0]                    state_q, state_d;
  logic [dxt_tm_pkg::ADDR_W-1:0] clr_cnt_q, clr_cnt_d;
  dxt_tm_pkg::entry_t            cur_q;
  logic                          pop;
  logic                          out_valid_q, out_valid_d;
  logic                          out_tr_q, out_tr_d;
  dxt_tm_pkg::status_e           out_sts_q, out_sts_d;
  logic                          produce;

  // A new operation starts only when the result register is free or draining;
  // nothing else can fill it while that operation is in flight.
  assign pop_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_o.ready);
  assign pop         = pop_valid_i && pop_ready_o;
  assign mem_re      = pop && (pop_entry_i.op == dxt_tm_pkg::OP_SET ||
                               pop_entry_i.op == dxt_tm_pkg::OP_QUERY);

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    mem_we    = 1'b0;
    mem_waddr = cur_q.addr;
    mem_wdata = rdata_q | cur_q.mask;
    produce   = 1'b0;
    out_tr_d  = out_tr_q;
    out_sts_d = out_sts_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pop) begin
          unique case (pop_entry_i.op)
            dxt_tm_pkg::OP_CLEAR: begin
              state_d   = ST_CLR;
              clr_cnt_d = '0;
            end
            dxt_tm_pkg::OP_SET, dxt_tm_pkg::OP_QUERY: state_d = ST_EXEC;
            default: begin
              produce   = 1'b1;
              out_tr_d  = 1'b0;
              out_sts_d = pop_entry_i.status;
            end
          endcase
        end
      end
      ST_EXEC: begin
        mem_we    = (cur_q.op == dxt_tm_pkg::OP_SET);
        produce   = 1'b1;
        out_tr_d  = (cur_q.op == dxt_tm_pkg::OP_QUERY) && (|(rdata_q & cur_q.mask));
        out_sts_d = cur_q.status;
        state_d   = ST_IDLE;
      end
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == LAST_ADDR) begin
          produce   = 1'b1;
          out_tr_d  = 1'b0;
          out_sts_d = dxt_tm_pkg::STS_DONE;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (produce) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q <= pop_entry_i;
    end
    out_tr_q  <= out_tr_d;
    out_sts_q <= out_sts_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[pop_entry_i.addr];
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.transparent = out_tr_q;
  assign out_o.status      = out_sts_q;

  `DXT_TM_ASSERT(a_exec_one_cycle, state_q == ST_EXEC |=> state_q == ST_IDLE,
                 "memory operation did not finish in one cycle")
  `DXT_TM_ASSERT(a_clear_starts_at_zero,
                 pop && pop_entry_i.op == dxt_tm_pkg::OP_CLEAR |=> clr_cnt_q == '0,
                 "clearing sweep did not start at the first entry")
  `DXT_TM_ASSERT(a_no_result_overwrite, produce |-> !out_valid_q || out_o.ready,
                 "result register overwritten before it was taken")
  `DXT_TM_ASSERT_ALWAYS(a_no_write_on_read, !(mem_we && mem_re),
                        "memory read and write in the same cycle")

endmodule

`default_nettype wire

[hdl/dxt_transparency_mask_store.sv]
// ----------------------------------------------------------------------------
// dxt_transparency_mask_store
// One-bit-per-pixel transparency map, loaded from DXT blocks or raw pixels.
// ----------------------------------------------------------------------------
// Command items arrive on in_i and each gives exactly one result item on out_o,
// in order. Configuration (width, height, source format) is to be written
// through cfg_we_i/cfg_idx_i/cfg_wdata_i only while the block is idle; the
// block itself does not enforce this. The front classifies an item in the
// cycle it is accepted and pushes it into a two-entry queue; the back owns the
// mask memory (one 16-bit word per 4x4 tile, one write and one registered read
// port). A result the front decides alone (ignored, out of range, opaque
// pixel) passes through the queue and the result register; a load or query
// that touches the memory also passes through the registered read, and it
// holds the back through the registered read followed by the write-back.
// A clear sweeps all 65536 words of the memory one word per cycle and then
// reports; later items wait in the queue meanwhile.
// Reset leaves the map absent, so nothing reads the memory before the first
// clear and no sweep follows reset. When out_o stalls, the result register
// holds, the back stops, the queue fills and in_i.ready falls.
// ----------------------------------------------------------------------------
`default_nettype none

module dxt_transparency_mask_store (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire  [dxt_tm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire  [dxt_tm_pkg::CFG_W-1:0]      cfg_wdata_i,
  dxt_tm_in_if.sink                         in_i,
  dxt_tm_out_if.source                      out_o
);

  logic               push_valid, push_ready;
  dxt_tm_pkg::entry_t push_entry;
  logic               pop_valid, pop_ready;
  dxt_tm_pkg::entry_t pop_entry;

  dxt_tm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_entry_o (push_entry),
    .push_ready_i (push_ready)
  );

  dxt_tm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_entry_i (push_entry),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_entry_o  (pop_entry),
    .pop_ready_i  (pop_ready)
  );

  dxt_tm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_entry_i (pop_entry),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

[bench/tb_dxt_transparency_mask_store.sv]
// ----------------------------------------------------------------------------
// tb_dxt_transparency_mask_store
// Self-checking bench for the transparency mask store.
// ----------------------------------------------------------------------------
// A directed table covers the cases that matter: no map yet, clear, raw pixel
// loads (both alpha values), DXT1 and DXT3 blocks, other compressed formats,
// wrong-format loads, partial blocks, zero and oversized image extents. Then
// random phases follow, each with its own image size and format. A local copy
// of the tile mask predicts each result item that the table does not set. Both
// handshakes stall at random, except in one stretch with no stalls at all.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_dxt_transparency_mask_store;

  localparam int RUN_LIMIT    = 3_000_000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 250;
  localparam int MAX_PRINTS   = 200;

  localparam logic [63:0] DXT1_ALL_MARKED = 64'hFFFF_FFFF_FFFF_0000;
  localparam logic [63:0] DXT1_REVERSED   = 64'hFFFF_FFFF_0000_FFFF;
  localparam logic [63:0] DXT1_EQUAL      = 64'hF0F0_0F0F_1234_1234;
  localparam logic [63:0] DXT3_MIXED      = 64'h0F0F_00F0_1234_5670;

  typedef struct {
    dxt_tm_pkg::cmd_e cmd;
    logic [63:0]      data;
    logic [7:0]       bcol;
    logic [7:0]       brow;
    logic [9:0]       px;
    logic [9:0]       py;
    logic             az;
  } mask_cmd_t;

  typedef struct {
    logic                transparent;
    dxt_tm_pkg::status_e status;
  } mask_res_t;

  typedef struct {
    bit               is_cfg;
    logic [10:0]      w;
    logic [10:0]      h;
    dxt_tm_pkg::fmt_e fmt;
    mask_cmd_t        c;
    bit               typed;
    mask_res_t        res;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic                             cfg_we;
  logic [dxt_tm_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [dxt_tm_pkg::CFG_W-1:0]     cfg_wdata;

  dxt_tm_in_if  cmd_if ();
  dxt_tm_out_if res_if ();

  dxt_transparency_mask_store u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (cmd_if),
    .out_o       (res_if)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Shadow copy of the mask and the register file.
  logic [15:0]      tile_mask [dxt_tm_pkg::DEPTH];
  bit               map_on;
  logic [10:0]      cur_w;
  logic [10:0]      cur_h;
  dxt_tm_pkg::fmt_e cur_fmt;

  mask_res_t   expected_q [$];
  plan_row_t   plan [$];
  int          mismatches = 0;
  int          cycle_cnt = 0;
  bit          steady;
  int          clears_left;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < MAX_PRINTS)
      $display("MISMATCH cycle %0d %s: got %0d expected %0d", cycle_cnt, what, got, want);
    mismatches++;
  endtask

  function automatic int unsigned clamp_extent(input logic [10:0] v, input int unsigned top);
    return (v > top) ? top : v;
  endfunction

  function automatic logic [15:0] tile_marks(input logic [63:0] d,
                                             input dxt_tm_pkg::fmt_e f);
    logic [15:0] m;
    m = '0;
    if (f == dxt_tm_pkg::FMT_DXT1 && d[15:0] <= d[31:16]) begin
      for (int k = 0; k < 16; k++) m[k] = (d[32+2*k +: 2] == dxt_tm_pkg::DXT1_IDX_TRANSP);
    end else if (f == dxt_tm_pkg::FMT_DXT3) begin
      for (int k = 0; k < 16; k++) m[k] = (d[4*k +: 4] == dxt_tm_pkg::DXT3_ALPHA_ZERO);
    end
    return m;
  endfunction

  // Applies one command item to the shadow mask and returns its result item.
  function automatic mask_res_t apply_mask_cmd(input mask_cmd_t c);
    mask_res_t   r;
    int unsigned w, h, word;
    logic [3:0]  bitpos;
    r.transparent = 1'b0;
    r.status      = dxt_tm_pkg::STS_DONE;
    w      = clamp_extent(cur_w, dxt_tm_pkg::MAX_WIDTH);
    h      = clamp_extent(cur_h, dxt_tm_pkg::MAX_HEIGHT);
    word   = c.py[9:2] * dxt_tm_pkg::BLOCKS_PER_ROW + c.px[9:2];
    bitpos = {c.py[1:0], c.px[1:0]};
    if (c.cmd == dxt_tm_pkg::CMD_CLEAR) begin
      foreach (tile_mask[i]) tile_mask[i] = '0;
      map_on = 1'b1;
    end else if (!map_on) begin
      r.status = dxt_tm_pkg::STS_IGNORED;
    end else if (c.cmd == dxt_tm_pkg::CMD_BLOCK) begin
      if (cur_fmt == dxt_tm_pkg::FMT_RAW) r.status = dxt_tm_pkg::STS_IGNORED;
      else if (c.bcol >= w / 4 || c.brow >= h / 4) r.status = dxt_tm_pkg::STS_RANGE;
      else tile_mask[c.brow * dxt_tm_pkg::BLOCKS_PER_ROW + c.bcol] |=
        tile_marks(c.data, cur_fmt);
    end else if (c.cmd == dxt_tm_pkg::CMD_PIXEL) begin
      if (cur_fmt != dxt_tm_pkg::FMT_RAW) r.status = dxt_tm_pkg::STS_IGNORED;
      else if (c.px >= w || c.py >= h) r.status = dxt_tm_pkg::STS_RANGE;
      else if (c.az) tile_mask[word][bitpos] = 1'b1;
    end else begin
      if (c.px >= w || c.py >= h) r.status = dxt_tm_pkg::STS_RANGE;
      else r.transparent = tile_mask[word][bitpos];
    end
    return r;
  endfunction

  function automatic plan_row_t item_row(input dxt_tm_pkg::cmd_e cmd, input logic [63:0] data,
                                         input int bc, input int br, input int px,
                                         input int py, input bit az, input bit typed,
                                         input bit tr, input dxt_tm_pkg::status_e st);
    plan_row_t row;
    row.is_cfg          = 1'b0;
    row.c.cmd           = cmd;
    row.c.data          = data;
    row.c.bcol          = 8'(bc);
    row.c.brow          = 8'(br);
    row.c.px            = 10'(px);
    row.c.py            = 10'(py);
    row.c.az            = az;
    row.typed           = typed;
    row.res.transparent = tr;
    row.res.status      = st;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(input int w, input int h, input dxt_tm_pkg::fmt_e f);
    plan_row_t row;
    row     = item_row(dxt_tm_pkg::CMD_QUERY, '0, 0, 0, 0, 0, 1'b0, 1'b0, 1'b0,
                       dxt_tm_pkg::STS_DONE);
    row.is_cfg = 1'b1;
    row.w   = 11'(w);
    row.h   = 11'(h);
    row.fmt = f;
    return row;
  endfunction

  function automatic void add_row(input plan_row_t row);
    plan.insert(plan.size(), row);
  endfunction

  function automatic logic [10:0] pick_extent();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 11'($urandom_range(4, 40));
    else if (r < 72) return 11'($urandom_range(1, 3));
    else if (r < 82) return 11'd1024;
    else if (r < 94) return 11'($urandom_range(41, 1023));
    else if (r < 97) return 11'd0;
    return 11'($urandom_range(1025, 2047));
  endfunction

  // Mostly in range when the image allows it, otherwise anywhere in the field.
  function automatic int unsigned pick_coord(input int unsigned limit, input int unsigned top);
    if (limit > 0 && $urandom_range(0, 3) != 0) return $urandom_range(0, limit - 1);
    return $urandom_range(0, top);
  endfunction

  function automatic mask_cmd_t random_cmd();
    mask_cmd_t   c;
    int unsigned w, h, r;
    w = clamp_extent(cur_w, dxt_tm_pkg::MAX_WIDTH);
    h = clamp_extent(cur_h, dxt_tm_pkg::MAX_HEIGHT);
    r = $urandom_range(0, 99);
    if (clears_left > 0 && $urandom_range(0, 249) == 0) begin
      c.cmd = dxt_tm_pkg::CMD_CLEAR;
      clears_left--;
    end else if (r < 45) begin
      c.cmd = (cur_fmt == dxt_tm_pkg::FMT_RAW) ? dxt_tm_pkg::CMD_PIXEL : dxt_tm_pkg::CMD_BLOCK;
    end else if (r < 55) begin
      c.cmd = (cur_fmt == dxt_tm_pkg::FMT_RAW) ? dxt_tm_pkg::CMD_BLOCK : dxt_tm_pkg::CMD_PIXEL;
    end else begin
      c.cmd = dxt_tm_pkg::CMD_QUERY;
    end
    c.data = {$urandom, $urandom};
    if (cur_fmt == dxt_tm_pkg::FMT_DXT1) begin
      if ($urandom_range(0, 9) == 0) c.data[31:16] = c.data[15:0];
      else if ($urandom_range(0, 3) != 0 && c.data[15:0] > c.data[31:16])
        c.data[31:0] = {c.data[15:0], c.data[31:16]};
    end else if (cur_fmt == dxt_tm_pkg::FMT_DXT3) begin
      for (int k = 0; k < 16; k++)
        if ($urandom_range(0, 3) == 0) c.data[4*k +: 4] = '0;
    end
    c.bcol = 8'(pick_coord(w / 4, 255));
    c.brow = 8'(pick_coord(h / 4, 255));
    c.px   = 10'(pick_coord(w, 1023));
    c.py   = 10'(pick_coord(h, 1023));
    c.az   = 1'($urandom_range(0, 1));
    return c;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so the next item can follow without a bubble.
  task automatic send_item(input mask_cmd_t c, input bit typed, input mask_res_t want);
    mask_res_t predicted;
    while (!steady && $urandom_range(0, 99) < 27) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_if.valid         <= 1'b1;
    cmd_if.command       <= c.cmd;
    cmd_if.block_data    <= c.data;
    cmd_if.block_col     <= c.bcol;
    cmd_if.block_row     <= c.brow;
    cmd_if.pixel_x       <= c.px;
    cmd_if.pixel_y       <= c.py;
    cmd_if.alpha_is_zero <= c.az;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    @(negedge clk);
    predicted = apply_mask_cmd(c);
    expected_q.insert(expected_q.size(), typed ? want : predicted);
  endtask

  task automatic drain();
    cmd_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  task automatic set_config(input logic [10:0] w, input logic [10:0] h,
                            input dxt_tm_pkg::fmt_e f);
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= dxt_tm_pkg::CFG_WIDTH;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_idx   <= dxt_tm_pkg::CFG_HEIGHT;
    cfg_wdata <= h;
    @(negedge clk);
    cfg_idx   <= dxt_tm_pkg::CFG_FORMAT;
    cfg_wdata <= {{(dxt_tm_pkg::CFG_W-2){1'b0}}, f};
    @(negedge clk);
    cfg_we  <= 1'b0;
    cur_w   = w;
    cur_h   = h;
    cur_fmt = f;
  endtask

  always @(negedge clk) res_if.ready <= steady || ($urandom_range(0, 99) >= 27);

  always @(posedge clk) begin : result_check
    mask_res_t head;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result item with none pending", res_if.status, -1);
      end else begin
        head = expected_q.pop_front();
        if (res_if.transparent !== head.transparent)
          report_mismatch("transparent", res_if.transparent, head.transparent);
        if (res_if.status !== head.status)
          report_mismatch("status", res_if.status, head.status);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == RUN_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    mask_res_t none;
    rst_n                = 1'b0;
    steady               = 1'b0;
    clears_left          = 3;
    map_on               = 1'b0;
    cur_w                = dxt_tm_pkg::SIZE_RESET;
    cur_h                = dxt_tm_pkg::SIZE_RESET;
    cur_fmt              = dxt_tm_pkg::FMT_RAW;
    foreach (tile_mask[i]) tile_mask[i] = '0;
    none.transparent     = 1'b0;
    none.status          = dxt_tm_pkg::STS_DONE;
    cfg_we               <= 1'b0;
    cfg_idx              <= dxt_tm_pkg::CFG_WIDTH;
    cfg_wdata            <= '0;
    cmd_if.valid         <= 1'b0;
    cmd_if.command       <= dxt_tm_pkg::CMD_CLEAR;
    cmd_if.block_data    <= '0;
    cmd_if.block_col     <= '0;
    cmd_if.block_row     <= '0;
    cmd_if.pixel_x       <= '0;
    cmd_if.pixel_y       <= '0;
    cmd_if.alpha_is_zero <= 1'b0;

    // Before the first clear there is no map, so loads and queries are ignored.
    add_row(item_row(dxt_tm_pkg::CMD_QUERY, '0, 0, 0, 0, 0, 1, 1, 0, dxt_tm_pkg::STS_IGNORED));
    add_row(item_row(dxt_tm_pkg::CMD_BLOCK, '0, 0, 0, 0, 0, 1, 1, 0, dxt_tm_pkg::STS_IGNORED));
    add_row(item_row(dxt_tm_pkg::CMD_PIXEL, '0, 0, 0, 0, 0, 1, 1, 0, dxt_tm_pkg::STS_IGNORED));
    add_row(item_row(dxt_tm_pkg::CMD_CLEAR, '1, 0, 0, 0, 0, 0, 1, 0, dxt_tm_pkg::STS_DONE));
    add_row(item_row(dxt_tm_pkg::CMD_PIXEL, '0, 0, 0, 0, 0, 1, 1, 0, dxt_tm_pkg::STS_DONE));
    add_row(item_row(dxt_tm_pkg::CMD_QUERY, '0, 0, 0, 0, 0, 0, 1, 1, dxt_tm_pkg::STS_DONE));
    add_row(item_row(dxt_tm_pkg::CMD_PIXEL, '0, 0, 0, 1023, 1023, 1, 1, 0,
                     dxt_tm_pkg::STS_DONE));
    add_row(item_row(dxt_tm_pkg::CMD_QUERY, '0, 0, 0, 1023, 1023, 0, 1, 1,
                     dxt_tm_pkg::STS_DONE));
    // An opaque pixel leaves the map as it was.
    add_row(item_row(dxt_tm_pkg::CMD_PIXEL, '0, 0, 0, 5, 5, 0, 1, 0, dxt_tm_pkg::STS_DONE));
    add_row(item_row(dxt_tm_pkg::CMD_QUERY, '0, 0, 0, 5, 5, 0, 1, 0, dxt_tm_pkg::STS_DONE));
    add_row(item_row(dxt_tm_pkg::CMD_BLOCK, '0, 0, 0, 0, 0, 0, 1, 0, dxt_tm_pkg::STS_IGNORED));
    add_row(cfg_row(1024, 1024, dxt_tm_pkg::FMT_DXT1));
    add_row(item_row(dxt_tm_pkg::CMD_PIXEL, '0, 0, 0, 2, 2, 1, 1, 0, dxt_tm_pkg::STS_IGNORED));
    add_row(item_row(dxt_tm_pkg::CMD_BLOCK, DXT1_ALL_MARKED, 255, 255, 0, 0, 0, 1, 0,
                     dxt_tm_pkg::STS_DONE));
    add_row(item_row(dxt_tm_pkg::CMD_QUERY, '0, 0, 0, 1022, 1021, 0, 0, 0,
                     dxt_tm_pkg::STS_DONE));
    // Colour0 above colour1 selects the opaque palette: nothing is marked.
    add_row(item_row(dxt_tm_pkg::CMD_BLOCK, DXT1_REVERSED, 0, 1, 0, 0, 0, 1, 0,
                     dxt_tm_pkg::STS_DONE));
    add_row(item_row(dxt_tm_pkg::CMD_QUERY, '0, 0, 0, 1, 5, 0, 0, 0, dxt_tm_pkg::STS_DONE));
    // A 10x6 image has two full block columns and one full block row.
    add_row(cfg_row(10, 6, dxt_tm_pkg::FMT_DXT1));
    add_row(item_row(dxt_tm_pkg::CMD_BLOCK, DXT1_ALL_MARKED, 2, 0, 0, 0, 0, 1, 0,
                     dxt_tm_pkg::STS_RANGE));
    add_row(item_row(dxt_tm_pkg::CMD_BLOCK, DXT1_EQUAL, 1, 0, 0, 0, 0, 1, 0,
                     dxt_tm_pkg::STS_DONE));
    add_row(item_row(dxt_tm_pkg::CMD_QUERY, '0, 0, 0, 10, 0, 0, 1, 0, dxt_tm_pkg::STS_RANGE));
    add_row(item_row(dxt_tm_pkg::CMD_QUERY, '0, 0, 0, 5, 2, 0, 0, 0, dxt_tm_pkg::STS_DONE));
    add_row(cfg_row(10, 6, dxt_tm_pkg::FMT_DXT3));
    add_row(item_row(dxt_tm_pkg::CMD_BLOCK, DXT3_MIXED, 0, 0, 0, 0, 0, 1, 0,
                     dxt_tm_pkg::STS_DONE));
    add_row(item_row(dxt_tm_pkg::CMD_QUERY, '0, 0, 0, 1, 0, 0, 0, 0, dxt_tm_pkg::STS_DONE));
    add_row(cfg_row(10, 6, dxt_tm_pkg::FMT_OTHER));
    add_row(item_row(dxt_tm_pkg::CMD_BLOCK, '0, 1, 0, 0, 0, 0, 1, 0, dxt_tm_pkg::STS_DONE));
    add_row(item_row(dxt_tm_pkg::CMD_BLOCK, '0, 0, 1, 0, 0, 0, 1, 0, dxt_tm_pkg::STS_RANGE));
    // Zero width puts every pixel out of range; oversized extents clamp.
    add_row(cfg_row(0, 1024, dxt_tm_pkg::FMT_OTHER));
    add_row(item_row(dxt_tm_pkg::CMD_QUERY, '0, 0, 0, 0, 0, 0, 1, 0, dxt_tm_pkg::STS_RANGE));
    add_row(cfg_row(2047, 2047, dxt_tm_pkg::FMT_RAW));
    add_row(item_row(dxt_tm_pkg::CMD_QUERY, '0, 0, 0, 1023, 1023, 0, 0, 0,
                     dxt_tm_pkg::STS_DONE));
    add_row(item_row(dxt_tm_pkg::CMD_CLEAR, '0, 0, 0, 0, 0, 0, 1, 0, dxt_tm_pkg::STS_DONE));
    add_row(item_row(dxt_tm_pkg::CMD_QUERY, '0, 0, 0, 1023, 1023, 0, 1, 0,
                     dxt_tm_pkg::STS_DONE));

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) set_config(plan[i].w, plan[i].h, plan[i].fmt);
      else send_item(plan[i].c, plan[i].typed, plan[i].res);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 1) set_config(11'd1, 11'd1, dxt_tm_pkg::fmt_e'(ph % 4));
      else set_config(pick_extent(), pick_extent(), dxt_tm_pkg::fmt_e'(ph % 4));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        steady = (ph == 3);
        send_item(random_cmd(), 1'b0, none);
      end
    end
    steady = 1'b0;

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

[dxt_transparency_mask_store.f]
+incdir+hdl
hdl/dxt_tm_pkg.sv
hdl/dxt_tm_if.sv
hdl/dxt_tm_front.sv
hdl/dxt_tm_queue.sv
hdl/dxt_tm_back.sv
hdl/dxt_transparency_mask_store.sv
bench/tb_dxt_transparency_mask_store.sv
